// ===== src/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants for the wash cycle sequencer.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned LevelW   = 10;
  localparam int unsigned HeatW    = 7;
  localparam int unsigned SecW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StateW   = 3;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned PumpW    = 2;

  localparam logic [SecW-1:0] SecMax = {SecW{1'b1}};

  // Register reset values
  localparam logic [LevelW-1:0] FillTargetRst  = LevelW'(40);
  localparam logic [HeatW-1:0]  HeatTargetRst  = HeatW'(60);
  localparam logic [LevelW-1:0] DrainDoneRst   = LevelW'(2);
  localparam logic [SecW-1:0]   ProcessSecsRst = SecW'(1800);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_ESTOP = 2'd2,
    FUNC_RESET = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILL_TARGET  = 2'd0,
    CFG_HEAT_TARGET  = 2'd1,
    CFG_DRAIN_DONE   = 2'd2,
    CFG_PROCESS_SECS = 2'd3
  } cfg_idx_e;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_INIT   = 8'b0000_0010,
    PH_INTAKE = 8'b0000_0100,
    PH_HEAT   = 8'b0000_1000,
    PH_PROC   = 8'b0001_0000,
    PH_DRAIN  = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_ERR    = 8'b1000_0000
  } phase_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE       = 3'd0,
    ERR_LOCK       = 3'd1,
    ERR_DOOR_FILL  = 3'd2,
    ERR_DOOR_HEAT  = 3'd3,
    ERR_DOOR_PROC  = 3'd4,
    ERR_EMERGENCY  = 3'd5
  } err_e;

  typedef enum logic [PumpW-1:0] {
    PUMP_OFF   = 2'd0,
    PUMP_FILL  = 2'd1,
    PUMP_DRAIN = 2'd2
  } pump_e;

  // Reported state codes
  localparam logic [StateW-1:0] StIdle   = 3'd0;
  localparam logic [StateW-1:0] StInit   = 3'd1;
  localparam logic [StateW-1:0] StIntake = 3'd2;
  localparam logic [StateW-1:0] StHeat   = 3'd3;
  localparam logic [StateW-1:0] StProc   = 3'd4;
  localparam logic [StateW-1:0] StDrain  = 3'd5;
  localparam logic [StateW-1:0] StDone   = 3'd6;
  localparam logic [StateW-1:0] StErr    = 3'd7;

  typedef struct packed {
    func_e             func;
    logic              door_locked;
    logic [LevelW-1:0] water_level;
    logic              heater_at_target;
  } acs_in_t;

  typedef struct packed {
    logic [StateW-1:0] cycle_state;
    logic [PumpW-1:0]  pump_cmd;
    logic [HeatW-1:0]  heater_setpoint;
    logic              lock_cmd;
    logic [ErrW-1:0]   error_code;
    logic [SecW-1:0]   elapsed_secs;
    logic              rejected;
  } acs_out_t;

  typedef struct packed {
    logic [LevelW-1:0] fill_target;
    logic [HeatW-1:0]  heat_target;
    logic [LevelW-1:0] drain_done;
    logic [SecW-1:0]   process_secs;
  } cfg_t;

  function automatic logic [StateW-1:0] phase_code(phase_e ph);
    logic [StateW-1:0] code;
    unique case (ph)
      PH_IDLE:   code = StIdle;
      PH_INIT:   code = StInit;
      PH_INTAKE: code = StIntake;
      PH_HEAT:   code = StHeat;
      PH_PROC:   code = StProc;
      PH_DRAIN:  code = StDrain;
      PH_DONE:   code = StDone;
      default:   code = StErr;
    endcase
    return code;
  endfunction

endpackage

// ===== src/acs_in_if.sv =====
// ----------------------------------------------------------------------------
// acs_in_if
// Event channel: valid/ready with one event beat as payload.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic              valid;
  logic              ready;
  acs_pkg::acs_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/acs_out_if.sv =====
// ----------------------------------------------------------------------------
// acs_out_if
// Status channel: valid/ready with one status beat as payload.
// ----------------------------------------------------------------------------
interface acs_out_if;
  logic              valid;
  logic              ready;
  acs_pkg::acs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/acs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acs_cfg_regs
// Setpoint register file, written through a plain write port.
// ----------------------------------------------------------------------------
module acs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [acs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [acs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output acs_pkg::cfg_t                    cfg_o
);

  acs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_target  <= acs_pkg::FillTargetRst;
      cfg_q.heat_target  <= acs_pkg::HeatTargetRst;
      cfg_q.drain_done   <= acs_pkg::DrainDoneRst;
      cfg_q.process_secs <= acs_pkg::ProcessSecsRst;
    end else if (cfg_we_i) begin
      unique case (acs_pkg::cfg_idx_e'(cfg_idx_i))
        acs_pkg::CFG_FILL_TARGET: begin
          cfg_q.fill_target <= cfg_wdata_i[acs_pkg::LevelW-1:0];
        end
        acs_pkg::CFG_HEAT_TARGET: begin
          cfg_q.heat_target <= cfg_wdata_i[acs_pkg::HeatW-1:0];
        end
        acs_pkg::CFG_DRAIN_DONE: begin
          cfg_q.drain_done <= cfg_wdata_i[acs_pkg::LevelW-1:0];
        end
        default: begin
          cfg_q.process_secs <= cfg_wdata_i[acs_pkg::SecW-1:0];
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/acs_seq.sv =====
// ----------------------------------------------------------------------------
// acs_seq
// Cycle state machine and timers; one event per step, status out combinational.
// ----------------------------------------------------------------------------
module acs_seq #(
  parameter int unsigned TICKS_PER_SEC   = 10,
  parameter int unsigned SELF_TEST_TICKS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  acs_pkg::acs_in_t   item_i,
  input  acs_pkg::cfg_t      cfg_i,
  output acs_pkg::acs_out_t  res_o
);

  localparam int unsigned SubW    = (TICKS_PER_SEC > 1) ? $clog2(TICKS_PER_SEC) : 1;
  localparam int unsigned SubCntW = SubW + 1;
  localparam logic [SubCntW-1:0] TpsVal = SubCntW'(TICKS_PER_SEC);
  localparam int unsigned SecW = acs_pkg::SecW;
  localparam logic [SecW-1:0] SelfTestVal = SecW'(SELF_TEST_TICKS);

  acs_pkg::phase_e phase_q, phase_d;
  acs_pkg::err_e   fault_q, fault_d;
  logic [SubW-1:0] sub_q, sub_d;      // subsecond ticks in processing
  logic [SecW-1:0] pt_q, pt_d;        // self-test ticks / processing seconds
  logic [SubW-1:0] csub_q, csub_d;    // cycle subsecond ticks
  logic [SecW-1:0] csec_q, csec_d;    // cycle seconds, saturating
  logic            rej;

  logic [SubCntW-1:0] sub_inc, csub_inc;
  logic               sub_wrap, csub_wrap;
  logic [SecW-1:0]    pt_inc;

  // pt never exceeds process_secs (16 bit) or the self-test count, so 16 bits hold it
  assign sub_inc   = {1'b0, sub_q} + SubCntW'(1);
  assign csub_inc  = {1'b0, csub_q} + SubCntW'(1);
  assign sub_wrap  = (sub_inc >= TpsVal);
  assign csub_wrap = (csub_inc >= TpsVal);
  assign pt_inc    = pt_q + SecW'(1);

  always_comb begin
    phase_d = phase_q;
    fault_d = fault_q;
    sub_d   = sub_q;
    pt_d    = pt_q;
    csub_d  = csub_q;
    csec_d  = csec_q;
    rej     = 1'b0;

    unique case (item_i.func)
      acs_pkg::FUNC_TICK: begin
        if (phase_q != acs_pkg::PH_IDLE) begin
          if (csub_wrap) begin
            csub_d = '0;
            if (csec_q != acs_pkg::SecMax) csec_d = csec_q + SecW'(1);
          end else begin
            csub_d = csub_inc[SubW-1:0];
          end
        end
        unique case (phase_q)
          acs_pkg::PH_INIT: begin
            if (pt_q == '0 && !item_i.door_locked) begin
              phase_d = acs_pkg::PH_ERR;
              fault_d = acs_pkg::ERR_LOCK;
            end else if (pt_inc >= SelfTestVal) begin
              phase_d = acs_pkg::PH_INTAKE;
              pt_d    = '0;
              sub_d   = '0;
            end else begin
              pt_d = pt_inc;
            end
          end
          acs_pkg::PH_INTAKE: begin
            if (!item_i.door_locked) begin
              phase_d = acs_pkg::PH_ERR;
              fault_d = acs_pkg::ERR_DOOR_FILL;
            end else if (item_i.water_level >= cfg_i.fill_target) begin
              phase_d = acs_pkg::PH_HEAT;
              pt_d    = '0;
              sub_d   = '0;
            end
          end
          acs_pkg::PH_HEAT: begin
            if (!item_i.door_locked) begin
              phase_d = acs_pkg::PH_ERR;
              fault_d = acs_pkg::ERR_DOOR_HEAT;
            end else if (item_i.heater_at_target) begin
              phase_d = acs_pkg::PH_PROC;
              pt_d    = '0;
              sub_d   = '0;
            end
          end
          acs_pkg::PH_PROC: begin
            if (!item_i.door_locked) begin
              phase_d = acs_pkg::PH_ERR;
              fault_d = acs_pkg::ERR_DOOR_PROC;
            end else if (pt_q >= cfg_i.process_secs) begin
              phase_d = acs_pkg::PH_DRAIN;
              pt_d    = '0;
              sub_d   = '0;
            end else if (sub_wrap) begin
              sub_d = '0;
              pt_d  = pt_inc;
            end else begin
              sub_d = sub_inc[SubW-1:0];
            end
          end
          acs_pkg::PH_DRAIN: begin
            if (item_i.water_level <= cfg_i.drain_done) begin
              phase_d = acs_pkg::PH_DONE;
              pt_d    = '0;
              sub_d   = '0;
            end
          end
          default: begin
          end
        endcase
      end
      acs_pkg::FUNC_START: begin
        if (phase_q == acs_pkg::PH_IDLE) begin
          phase_d = acs_pkg::PH_INIT;
          pt_d    = '0;
          sub_d   = '0;
          fault_d = acs_pkg::ERR_NONE;
          csub_d  = '0;
          csec_d  = '0;
        end else begin
          rej = 1'b1;
        end
      end
      acs_pkg::FUNC_ESTOP: begin
        phase_d = acs_pkg::PH_ERR;
        fault_d = acs_pkg::ERR_EMERGENCY;
      end
      default: begin
        if (phase_q == acs_pkg::PH_DONE || phase_q == acs_pkg::PH_ERR) begin
          phase_d = acs_pkg::PH_IDLE;
          pt_d    = '0;
          sub_d   = '0;
          fault_d = acs_pkg::ERR_NONE;
        end else begin
          rej = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= acs_pkg::PH_IDLE;
      fault_q <= acs_pkg::ERR_NONE;
      sub_q   <= '0;
      pt_q    <= '0;
      csub_q  <= '0;
      csec_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fault_q <= fault_d;
      sub_q   <= sub_d;
      pt_q    <= pt_d;
      csub_q  <= csub_d;
      csec_q  <= csec_d;
    end
  end

  // Status reflects the state after this event
  always_comb begin
    res_o.cycle_state = acs_pkg::phase_code(phase_d);
    if (phase_d == acs_pkg::PH_INTAKE) begin
      res_o.pump_cmd = acs_pkg::PUMP_FILL;
    end else if (phase_d == acs_pkg::PH_DRAIN) begin
      res_o.pump_cmd = acs_pkg::PUMP_DRAIN;
    end else begin
      res_o.pump_cmd = acs_pkg::PUMP_OFF;
    end
    res_o.heater_setpoint = (phase_d == acs_pkg::PH_HEAT || phase_d == acs_pkg::PH_PROC)
                            ? cfg_i.heat_target : '0;
    res_o.lock_cmd     = (phase_d != acs_pkg::PH_IDLE && phase_d != acs_pkg::PH_DONE);
    res_o.error_code   = fault_d;
    res_o.elapsed_secs = csec_d;
    res_o.rejected     = rej;
  end

endmodule

// ===== src/appliance_cycle_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// appliance_cycle_sequencer_core
// Wash cycle sequencer: takes tick/start/stop/reset events with sensor
// readings and returns one status beat per event.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Beat contents
//  --------  ---  -----------------  ----------------------------------------
//  in_i      in   valid/ready        func, door_locked, water_level,
//                                    heater_at_target
//  out_o     out  valid/ready        cycle_state, pump_cmd, heater_setpoint,
//                                    lock_cmd, error_code, elapsed_secs,
//                                    rejected
//  cfg_*     in   write enable only  fill_target, heat_target, drain_done,
//                                    process_secs (index 0..3)
//
//  One event beat per clock while the output is not stalled; the event lands in
//  the input register, and when it steps the next-state logic writes its status
//  into the output register. The event register and status register each hold
//  one beat, so a stalled output still lets one more event in before the input
//  backs up; throughput is set by the single next-state step per cycle. Reset
//  clears the cycle state to idle, the timers to zero and loads the default
//  setpoints; no clearing pass is needed.
//
module appliance_cycle_sequencer_core #(
  parameter int unsigned TICKS_PER_SEC   = 10,
  parameter int unsigned SELF_TEST_TICKS = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  acs_in_if.sink                       in_i,
  acs_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [acs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acs_pkg::CfgDataW-1:0] cfg_wdata_i
);

  acs_pkg::cfg_t     cfg;
  acs_pkg::acs_in_t  in_data_q;
  logic              in_vld_q;
  acs_pkg::acs_out_t out_data_q;
  logic              out_vld_q;
  acs_pkg::acs_out_t res;
  logic              out_free;
  logic              step;
  logic              in_rdy;

  acs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_q || out_o.ready;
  // Held event advances through the state machine into the output slot
  assign step     = in_vld_q && out_free;
  assign in_rdy   = !in_vld_q || step;
  assign in_i.ready = in_rdy;

  acs_seq #(
    .TICKS_PER_SEC   (TICKS_PER_SEC),
    .SELF_TEST_TICKS (SELF_TEST_TICKS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      in_data_q <= in_i.data;
    end
  end

  // Status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

endmodule
